// ----- design/head_length_tail_deframer_defines.svh -----
// assertion macros shared by the deframer modules
`ifndef HEAD_LENGTH_TAIL_DEFRAMER_DEFINES_SVH
`define HEAD_LENGTH_TAIL_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HLTD_ASSERT_IMP(name, clk, rst, pre, post) \
name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
   else $error("deframer check failed");

// next-cycle implication
`define HLTD_ASSERT_NEXT(name, clk, rst, pre, post) \
name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
   else $error("deframer check failed");

`else

`define HLTD_ASSERT_IMP(name, clk, rst, pre, post)
`define HLTD_ASSERT_NEXT(name, clk, rst, pre, post)

`endif

`endif

// ----- design/hltd_pkg.sv -----
package hltd_pkg;

   // sizes
   localparam int MAX_PAYLOAD = 63;
   localparam int STORE_DEPTH = 64;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int Q_DEPTH     = 128;
   localparam int Q_AW        = $clog2(Q_DEPTH);
   localparam int Q_CW        = Q_AW + 1;
   localparam int CSR_AW      = 2;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_HEAD_VALUE = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_TAIL_VALUE = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_BIG_ENDIAN = 2'd2;

   // parser phase
   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_LEN1 = 3'd1,
      PH_LEN2 = 3'd2,
      PH_DATA = 3'd3,
      PH_TAIL = 3'd4
   } phase_type;

   // what one parsed byte asks for
   typedef enum logic [2:0] {
      TK_NONE  = 3'd0,
      TK_EMIT  = 3'd1,
      TK_EMPTY = 3'd2,
      TK_FAIL  = 3'd3,
      TK_LONG  = 3'd4
   } take_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE      = 4'd0,
      ST_QREAD     = 4'd1,
      ST_QTAKE     = 4'd2,
      ST_EMIT_RD   = 4'd3,
      ST_EMIT_LD   = 4'd4,
      ST_EMPTY     = 4'd5,
      ST_FAIL_TAIL = 4'd6,
      ST_FAIL_RD   = 4'd7,
      ST_FAIL_WR   = 4'd8,
      ST_LEN_B     = 4'd9,
      ST_LEN_A     = 4'd10
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic take_in;
      logic take_q;
      logic idx_inc;
      logic idx_dec;
      logic out_store;
      logic out_empty;
      logic push_cur;
      logic push_flb;
      logic push_store;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      take_type outcome;
      logic     q_empty;
      logic     q_one;
      logic     out_free;
      logic     idx_last;
      logic     idx_zero;
      logic     cnt_zero;
   } dp_sts_type;

endpackage

// ----- design/hltd_ram.sv -----
module hltd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- design/hltd_dpath.sv -----
`include "head_length_tail_deframer_defines.svh"

module hltd_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [7:0]                         req_in_byte,
   input  logic                               csr_valid,
   input  logic [hltd_pkg::CSR_AW-1:0]        csr_index,
   input  logic [7:0]                         csr_data,
   input  hltd_pkg::dp_cmd_type               cmd,
   output hltd_pkg::dp_sts_type               sts,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_last_byte,
   output logic                               rsp_empty_frame
);

   logic [7:0] head_ff, tail_ff;
   logic       big_ff;

   hltd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]                   flb_ff, flb_in;
   logic [hltd_pkg::STORE_AW-1:0] flen_ff, flen_in;
   logic [hltd_pkg::STORE_AW-1:0] pc_ff, pc_in;
   logic [hltd_pkg::STORE_AW-1:0] ecnt_ff, ecnt_in;
   logic [hltd_pkg::STORE_AW-1:0] idx_ff, idx_in;
   logic [7:0]                   cur_ff;
   logic [hltd_pkg::Q_AW-1:0]    qh_ff;
   logic [hltd_pkg::Q_CW-1:0]    qc_ff;

   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff, rsp_empty_ff;

   logic                         take_en;
   logic [7:0]                   take_b;
   logic [15:0]                  len16;
   logic [hltd_pkg::STORE_AW:0]  pc_next;
   logic                         st_we;
   hltd_pkg::take_type           outcome;
   logic [7:0]                   st_rdata, q_rdata, q_wdata;
   logic                         q_we;
   logic [hltd_pkg::Q_AW-1:0]    q_waddr;
   logic                         out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         big_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            hltd_pkg::CSR_HEAD_VALUE: head_ff <= csr_data;
            hltd_pkg::CSR_TAIL_VALUE: tail_ff <= csr_data;
            hltd_pkg::CSR_BIG_ENDIAN: big_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // byte source for the parser
   assign take_en = cmd.take_in | cmd.take_q;
   assign take_b  = cmd.take_q ? q_rdata : req_in_byte;
   assign len16   = big_ff ? {flb_ff, take_b} : {take_b, flb_ff};
   assign pc_next = {1'b0, pc_ff} + (hltd_pkg::STORE_AW + 1)'(1);

   // parser step for one byte
   always_comb begin
      phase_in = phase_ff;
      flb_in   = flb_ff;
      flen_in  = flen_ff;
      pc_in    = pc_ff;
      ecnt_in  = ecnt_ff;
      idx_in   = idx_ff;
      st_we    = 1'b0;
      outcome  = hltd_pkg::TK_NONE;
      case (phase_ff)
         hltd_pkg::PH_LEN1: begin
            flb_in   = take_b;
            phase_in = hltd_pkg::PH_LEN2;
         end
         hltd_pkg::PH_LEN2: begin
            pc_in = '0;
            if (len16 > 16'(hltd_pkg::MAX_PAYLOAD)) begin
               phase_in = hltd_pkg::PH_HUNT;
               outcome  = hltd_pkg::TK_LONG;
            end else begin
               flen_in = len16[hltd_pkg::STORE_AW-1:0];
               if (len16 == 16'd0) begin
                  phase_in = hltd_pkg::PH_TAIL;
               end else begin
                  phase_in = hltd_pkg::PH_DATA;
               end
            end
         end
         hltd_pkg::PH_DATA: begin
            st_we = 1'b1;
            pc_in = pc_next[hltd_pkg::STORE_AW-1:0];
            if (pc_next >= {1'b0, flen_ff}) begin
               phase_in = hltd_pkg::PH_TAIL;
            end
         end
         hltd_pkg::PH_TAIL: begin
            phase_in = hltd_pkg::PH_HUNT;
            pc_in    = '0;
            ecnt_in  = pc_ff;
            if (take_b == tail_ff) begin
               idx_in = '0;
               if (pc_ff == '0) begin
                  outcome = hltd_pkg::TK_EMPTY;
               end else begin
                  outcome = hltd_pkg::TK_EMIT;
               end
            end else begin
               idx_in  = pc_ff - 1'b1;
               outcome = hltd_pkg::TK_FAIL;
            end
         end
         default: begin
            if (take_b == head_ff) begin
               phase_in = hltd_pkg::PH_LEN1;
            end else begin
               phase_in = hltd_pkg::PH_HUNT;
            end
         end
      endcase
   end

   // parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hltd_pkg::PH_HUNT;
         pc_ff    <= '0;
      end else if (take_en) begin
         phase_ff <= phase_in;
         pc_ff    <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_en) begin
         flb_ff  <= flb_in;
         flen_ff <= flen_in;
         ecnt_ff <= ecnt_in;
         cur_ff  <= take_b;
      end
   end

   // store / emit index
   always_ff @(posedge clock) begin
      if (take_en) begin
         idx_ff <= idx_in;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_ff - 1'b1;
      end
   end

   // payload store
   hltd_ram #(
      .WIDTH(8),
      .DEPTH(hltd_pkg::STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (st_we & take_en),
      .wr_addr(pc_ff),
      .wr_data(take_b),
      .rd_addr(idx_ff),
      .rd_data(st_rdata)
   );

   // replay queue, pushed at the front, popped at the front
   assign q_we    = cmd.push_cur | cmd.push_flb | cmd.push_store;
   assign q_waddr = qh_ff - 1'b1;
   always_comb begin
      if (cmd.push_cur) begin
         q_wdata = cur_ff;
      end else if (cmd.push_flb) begin
         q_wdata = flb_ff;
      end else begin
         q_wdata = st_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qh_ff <= '0;
         qc_ff <= '0;
      end else if (q_we) begin
         qh_ff <= qh_ff - 1'b1;
         qc_ff <= qc_ff + 1'b1;
      end else if (cmd.take_q) begin
         qh_ff <= qh_ff + 1'b1;
         qc_ff <= qc_ff - 1'b1;
      end
   end

   hltd_ram #(
      .WIDTH(8),
      .DEPTH(hltd_pkg::Q_DEPTH)
   ) u_queue (
      .clock  (clock),
      .wr_en  (q_we),
      .wr_addr(q_waddr),
      .wr_data(q_wdata),
      .rd_addr(qh_ff),
      .rd_data(q_rdata)
   );

   // result output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_store || cmd.out_empty) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_store) begin
         rsp_byte_ff  <= st_rdata;
         rsp_last_ff  <= sts.idx_last;
         rsp_empty_ff <= 1'b0;
      end else if (cmd.out_empty) begin
         rsp_byte_ff  <= '0;
         rsp_last_ff  <= 1'b1;
         rsp_empty_ff <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_byte   = rsp_last_ff;
   assign rsp_empty_frame = rsp_empty_ff;

   // status
   assign sts.outcome  = outcome;
   assign sts.q_empty  = (qc_ff == '0);
   assign sts.q_one    = (qc_ff == hltd_pkg::Q_CW'(1));
   assign sts.out_free = out_free;
   assign sts.idx_last = (({1'b0, idx_ff} + (hltd_pkg::STORE_AW + 1)'(1)) == {1'b0, ecnt_ff});
   assign sts.idx_zero = (idx_ff == '0);
   assign sts.cnt_zero = (ecnt_ff == '0);

   // checks
   `HLTD_ASSERT_IMP(a_q_bound, clock, reset, 1'b1, qc_ff <= hltd_pkg::Q_CW'(hltd_pkg::Q_DEPTH))
   `HLTD_ASSERT_IMP(a_pc_below_len, clock, reset, phase_ff == hltd_pkg::PH_DATA, pc_ff < flen_ff)
   `HLTD_ASSERT_NEXT(a_push_grows, clock, reset, q_we, qc_ff == $past(qc_ff) + 1'b1)

endmodule

// ----- design/hltd_ctrl.sv -----
`include "head_length_tail_deframer_defines.svh"

module hltd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  hltd_pkg::dp_sts_type sts,
   output hltd_pkg::dp_cmd_type cmd
);

   hltd_pkg::ctl_state_type state_ff, state_in, resume;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hltd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // where to go once a sequence is done
   always_comb begin
      if (sts.q_empty) begin
         resume = hltd_pkg::ST_IDLE;
      end else begin
         resume = hltd_pkg::ST_QREAD;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hltd_pkg::ST_IDLE, hltd_pkg::ST_QTAKE: begin
            if (state_ff == hltd_pkg::ST_QTAKE || req_valid) begin
               case (sts.outcome)
                  hltd_pkg::TK_EMIT:  state_in = hltd_pkg::ST_EMIT_RD;
                  hltd_pkg::TK_EMPTY: state_in = hltd_pkg::ST_EMPTY;
                  hltd_pkg::TK_FAIL:  state_in = hltd_pkg::ST_FAIL_TAIL;
                  hltd_pkg::TK_LONG:  state_in = hltd_pkg::ST_LEN_B;
                  default: begin
                     if (state_ff == hltd_pkg::ST_QTAKE && !sts.q_one) begin
                        state_in = hltd_pkg::ST_QREAD;
                     end else begin
                        state_in = hltd_pkg::ST_IDLE;
                     end
                  end
               endcase
            end
         end
         hltd_pkg::ST_QREAD:   state_in = hltd_pkg::ST_QTAKE;
         hltd_pkg::ST_EMIT_RD: state_in = hltd_pkg::ST_EMIT_LD;
         hltd_pkg::ST_EMIT_LD: begin
            if (sts.out_free) begin
               state_in = sts.idx_last ? resume : hltd_pkg::ST_EMIT_RD;
            end
         end
         hltd_pkg::ST_EMPTY: begin
            if (sts.out_free) begin
               state_in = resume;
            end
         end
         hltd_pkg::ST_FAIL_TAIL: begin
            state_in = sts.cnt_zero ? hltd_pkg::ST_QREAD : hltd_pkg::ST_FAIL_RD;
         end
         hltd_pkg::ST_FAIL_RD: state_in = hltd_pkg::ST_FAIL_WR;
         hltd_pkg::ST_FAIL_WR: begin
            state_in = sts.idx_zero ? hltd_pkg::ST_QREAD : hltd_pkg::ST_FAIL_RD;
         end
         hltd_pkg::ST_LEN_B: state_in = hltd_pkg::ST_LEN_A;
         hltd_pkg::ST_LEN_A: state_in = hltd_pkg::ST_QREAD;
         default:            state_in = hltd_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         hltd_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.take_in = req_valid;
         end
         hltd_pkg::ST_QTAKE: cmd.take_q = 1'b1;
         hltd_pkg::ST_EMIT_LD: begin
            cmd.out_store = sts.out_free;
            cmd.idx_inc   = sts.out_free && !sts.idx_last;
         end
         hltd_pkg::ST_EMPTY:     cmd.out_empty = sts.out_free;
         hltd_pkg::ST_FAIL_TAIL: cmd.push_cur  = 1'b1;
         hltd_pkg::ST_FAIL_WR: begin
            cmd.push_store = 1'b1;
            cmd.idx_dec    = !sts.idx_zero;
         end
         hltd_pkg::ST_LEN_B: cmd.push_cur = 1'b1;
         hltd_pkg::ST_LEN_A: cmd.push_flb = 1'b1;
         default: ;
      endcase
   end

   // checks
   `HLTD_ASSERT_IMP(a_load_free, clock, reset, cmd.out_store || cmd.out_empty, sts.out_free)
   `HLTD_ASSERT_IMP(a_take_q_nonempty, clock, reset, state_ff == hltd_pkg::ST_QTAKE, !sts.q_empty)

endmodule

// ----- design/head_length_tail_deframer.sv -----
// Frame recovery from a byte stream: head byte, 16-bit length (byte order from
// big_endian), payload of up to 63 bytes, tail byte. While hunting or filling a
// frame the block takes one byte per cycle. A byte that closes a good frame
// starts emission of its payload, each result byte by a store read and then a
// load of the output register, or one empty-frame result for length zero. A bad
// tail pushes the failing byte into the replay queue and then the stored payload
// after it, each stored byte by a store read and then a queue write; an oversized
// length pushes its two length bytes. Queued bytes then pass through the parser,
// each by a registered queue read and then a parse, before the next input beat
// is taken. These read steps come from the registered reads of the payload store
// and replay queue. Configuration writes are always ready and are registered.
module head_length_tail_deframer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_in_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last_byte,
   output logic                        rsp_empty_frame,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [hltd_pkg::CSR_AW-1:0] csr_index,
   input  logic [7:0]                  csr_data
);

   hltd_pkg::dp_cmd_type cmd;
   hltd_pkg::dp_sts_type sts;

   assign csr_ready = 1'b1;

   // sequencing
   hltd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   // parser, store, replay queue and output register
   hltd_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_in_byte    (req_in_byte),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte),
      .rsp_empty_frame(rsp_empty_frame)
   );

endmodule
